// File: rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; clk_i and rst_ni must exist where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is active
`define TLZWD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked check that also holds while reset is active
`define TLZWD_ASSERT_ANY(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/tlzwd_pkg.sv
// shared types, constants and address helpers for the lz window decompressor
// no dependencies
package tlzwd_pkg;

  // history window
  localparam int unsigned HistDepth = 4096;
  localparam int unsigned HistAw    = $clog2(HistDepth);

  typedef logic [HistAw-1:0] hist_addr_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RAW_HI,
    ST_COPY
  } seq_state_e;

  // one byte handed from the sequencer to the output stage
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } emit_t;

  // next window position with wrap
  function automatic hist_addr_t hist_inc(input hist_addr_t a);
    hist_addr_t r;
    if (a == hist_addr_t'(HistDepth - 1)) begin
      r = '0;
    end else begin
      r = a + 1'b1;
    end
    return r;
  endfunction

  // position (off + 1) bytes back from a, with wrap
  function automatic hist_addr_t hist_back(input hist_addr_t a, input logic [11:0] off);
    logic [HistAw:0] diff;
    diff = {1'b0, a} - (HistAw + 1)'(off) - 1'b1;
    if (diff[HistAw]) begin
      diff = diff + (HistAw + 1)'(HistDepth);
    end
    return diff[HistAw-1:0];
  endfunction

endpackage

// File: rtl/tlzwd_ram.sv
// generic single-write, single-read memory with registered read data
// read returns the old contents when the same entry is written in that cycle
module tlzwd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tlzwd_seq.sv
// token decoder and history sequencer: decodes tokens, drives the history memory
// depends on tlzwd_pkg
module tlzwd_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [15:0]           token_i,
  input  logic                  stream_start_i,
  input  logic                  adv_i,
  output tlzwd_pkg::emit_t      emit_o,
  output logic                  ram_we_o,
  output tlzwd_pkg::hist_addr_t ram_waddr_o,
  output logic [7:0]            ram_wdata_o,
  output logic                  ram_re_o,
  output tlzwd_pkg::hist_addr_t ram_raddr_o,
  input  logic [7:0]            ram_rdata_i
);

  tlzwd_pkg::seq_state_e state_q, state_d;
  tlzwd_pkg::hist_addr_t wpos_q, wpos_d;
  tlzwd_pkg::hist_addr_t src_q, src_d;
  logic                  wrapped_q, wrapped_d;
  logic [3:0]            raw_left_q, raw_left_d;
  logic                  rejected_q, rejected_d;
  logic [3:0]            cnt_q, cnt_d;
  logic [7:0]            hi_q, hi_d;
  logic                  fwd_q, fwd_d;
  logic [7:0]            fwd_data_q, fwd_data_d;
  logic                  hit_q, hit_d;

  logic                  accept;
  logic [3:0]            nib;
  tlzwd_pkg::hist_addr_t wpos_eff;
  logic                  wrapped_eff;
  logic [3:0]            raw_eff;
  logic                  rej_eff;
  logic [7:0]            copy_byte;
  tlzwd_pkg::hist_addr_t src_first;
  tlzwd_pkg::hist_addr_t src_next;

  // request handshake, one token at a time
  assign in_ready_o = (state_q == tlzwd_pkg::ST_IDLE) && adv_i;
  assign accept     = in_valid_i && in_ready_o;
  assign nib        = token_i[15:12];

  // stream start clears position, wrap flag and raw count and sets rejection from the token before decode
  assign wpos_eff    = stream_start_i ? '0 : wpos_q;
  assign wrapped_eff = stream_start_i ? 1'b0 : wrapped_q;
  assign raw_eff     = stream_start_i ? 4'd0 : raw_left_q;
  assign rej_eff     = stream_start_i ? (nib != 4'd0) : rejected_q;

  // copy byte: forwarded write, stored entry, or zero for unwritten entries
  assign copy_byte = fwd_q ? fwd_data_q : (hit_q ? ram_rdata_i : 8'h00);

  assign src_first = tlzwd_pkg::hist_back(wpos_eff, token_i[11:0]);
  assign src_next  = tlzwd_pkg::hist_inc(src_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlzwd_pkg::ST_IDLE: begin
        if (accept && !rej_eff) begin
          if (raw_eff != 4'd0) begin
            state_d = tlzwd_pkg::ST_RAW_HI;
          end else if (nib != 4'd0) begin
            state_d = tlzwd_pkg::ST_COPY;
          end
        end
      end
      tlzwd_pkg::ST_RAW_HI: begin
        if (adv_i) begin
          state_d = tlzwd_pkg::ST_IDLE;
        end
      end
      tlzwd_pkg::ST_COPY: begin
        if (adv_i && (cnt_q == 4'd0)) begin
          state_d = tlzwd_pkg::ST_IDLE;
        end
      end
      default: state_d = tlzwd_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    emit_o      = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = wpos_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = src_q;
    wpos_d      = wpos_q;
    wrapped_d   = wrapped_q;
    raw_left_d  = raw_left_q;
    rejected_d  = rejected_q;
    cnt_d       = cnt_q;
    src_d       = src_q;
    hi_d        = hi_q;
    fwd_d       = fwd_q;
    fwd_data_d  = fwd_data_q;
    hit_d       = hit_q;
    unique case (state_q)
      tlzwd_pkg::ST_IDLE: begin
        if (accept) begin
          wpos_d     = wpos_eff;
          wrapped_d  = wrapped_eff;
          raw_left_d = raw_eff;
          rejected_d = rej_eff;
          if (!rej_eff) begin
            if (raw_eff != 4'd0) begin
              // raw word, low byte now, high byte next
              emit_o      = '{valid: 1'b1, data: token_i[7:0], last: 1'b0};
              ram_we_o    = 1'b1;
              ram_waddr_o = wpos_eff;
              wpos_d      = tlzwd_pkg::hist_inc(wpos_eff);
              wrapped_d   = wrapped_eff || (wpos_eff == tlzwd_pkg::hist_addr_t'(
                              tlzwd_pkg::HistDepth - 1));
              raw_left_d  = raw_eff - 4'd1;
              hi_d        = token_i[15:8];
            end else if (nib == 4'd0) begin
              // literal byte, loads the raw word count
              emit_o      = '{valid: 1'b1, data: token_i[7:0], last: 1'b1};
              ram_we_o    = 1'b1;
              ram_waddr_o = wpos_eff;
              wpos_d      = tlzwd_pkg::hist_inc(wpos_eff);
              wrapped_d   = wrapped_eff || (wpos_eff == tlzwd_pkg::hist_addr_t'(
                              tlzwd_pkg::HistDepth - 1));
              raw_left_d  = token_i[11:8];
            end else begin
              // back reference, first history read
              ram_re_o    = 1'b1;
              ram_raddr_o = src_first;
              src_d       = src_first;
              cnt_d       = nib;
              fwd_d       = 1'b0;
              hit_d       = wrapped_eff || (src_first < wpos_eff);
            end
          end
        end
      end
      tlzwd_pkg::ST_RAW_HI: begin
        if (adv_i) begin
          emit_o    = '{valid: 1'b1, data: hi_q, last: 1'b1};
          ram_we_o  = 1'b1;
          wpos_d    = tlzwd_pkg::hist_inc(wpos_q);
          wrapped_d = wrapped_q || (wpos_q == tlzwd_pkg::hist_addr_t'(
                        tlzwd_pkg::HistDepth - 1));
        end
      end
      tlzwd_pkg::ST_COPY: begin
        if (adv_i) begin
          // write back the copied byte and fetch the next one
          emit_o    = '{valid: 1'b1, data: copy_byte, last: (cnt_q == 4'd0)};
          ram_we_o  = 1'b1;
          wpos_d    = tlzwd_pkg::hist_inc(wpos_q);
          wrapped_d = wrapped_q || (wpos_q == tlzwd_pkg::hist_addr_t'(
                        tlzwd_pkg::HistDepth - 1));
          if (cnt_q != 4'd0) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = src_next;
            src_d       = src_next;
            cnt_d       = cnt_q - 4'd1;
            // same entry written this cycle: forward the byte
            fwd_d       = (src_next == wpos_q);
            fwd_data_d  = copy_byte;
            hit_d       = wrapped_q || (src_next < wpos_q);
          end
        end
      end
      default: begin
        emit_o = '0;
      end
    endcase
  end

  assign ram_wdata_o = emit_o.data;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tlzwd_pkg::ST_IDLE;
      wpos_q     <= '0;
      wrapped_q  <= 1'b0;
      raw_left_q <= 4'd0;
      rejected_q <= 1'b0;
      cnt_q      <= 4'd0;
      fwd_q      <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      wpos_q     <= wpos_d;
      wrapped_q  <= wrapped_d;
      raw_left_q <= raw_left_d;
      rejected_q <= rejected_d;
      cnt_q      <= cnt_d;
      fwd_q      <= fwd_d;
      hit_q      <= hit_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    hi_q       <= hi_d;
    fwd_data_q <= fwd_data_d;
  end

endmodule

// File: rtl/tlzwd_out.sv
// output register between the sequencer and the result channel
// depends on tlzwd_pkg
module tlzwd_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlzwd_pkg::emit_t emit_i,
  output logic             adv_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;

  // slot is free when empty or taken this cycle
  assign adv_o   = !valid_q || out_ready_i;
  assign valid_d = adv_o ? emit_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // load the byte when a new one arrives
  always_ff @(posedge clk_i) begin
    if (adv_o && emit_i.valid) begin
      byte_q <= emit_i.data;
      last_q <= emit_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign run_last_o  = last_q;

endmodule

// File: rtl/token_lz_window_decompressor_unit.sv
// path: a literal or raw byte passes the output register, a copy byte the history read
//   register and then the output register; a new token is taken only in idle, after the
//   previous token's last byte; each copied byte takes one read of the single read port
// reset: control state clears at once; the history memory is not swept, entries not
//   written since the stream start read as zero through the write-position compare
// top level of the lz window decompressor; depends on tlzwd_pkg, tlzwd_seq, tlzwd_ram, tlzwd_out
module token_lz_window_decompressor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] token_i,
  input  logic        stream_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o
);

  tlzwd_pkg::emit_t      emit;
  logic                  adv;
  logic                  ram_we;
  tlzwd_pkg::hist_addr_t ram_waddr;
  logic [7:0]            ram_wdata;
  logic                  ram_re;
  tlzwd_pkg::hist_addr_t ram_raddr;
  logic [7:0]            ram_rdata;

  // token decode and history sequencing
  tlzwd_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .token_i        (token_i),
    .stream_start_i (stream_start_i),
    .adv_i          (adv),
    .emit_o         (emit),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  // history window
  tlzwd_ram #(
    .Width (8),
    .Depth (tlzwd_pkg::HistDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result register
  tlzwd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

// File: rtl/tlzwd_chk.sv
// port-level checks for the lz window decompressor, bound to the top level
// depends on assert_macros.svh and token_lz_window_decompressor_unit
`include "assert_macros.svh"

module tlzwd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [15:0] token_i,
  input logic        stream_start_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic        run_last_o
);

  // a stalled result holds
  `TLZWD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(run_last_o), "result changed while stalled")

  // no result while in reset
  `TLZWD_ASSERT_ANY(a_rst_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")

  // no new request while a token still has bytes to give
  `TLZWD_ASSERT(a_one_token, out_valid_o && !run_last_o |-> !in_ready_o, "request taken mid token")

  // rejected stream start gives nothing
  `TLZWD_ASSERT(a_reject, in_valid_i && in_ready_o && stream_start_i && token_i[15:12] != 4'd0 |=> !out_valid_o, "rejected stream produced a byte")

  // literal at stream start gives its low byte as the only byte
  `TLZWD_ASSERT(a_start_lit, in_valid_i && in_ready_o && stream_start_i && token_i[15:12] == 4'd0 |=> out_valid_o && run_last_o && out_byte_o == $past(token_i[7:0]), "wrong literal at stream start")

endmodule

bind token_lz_window_decompressor_unit tlzwd_chk u_chk (.*);
